// ===== src/pump_moisture_run_lockout_control_assert.svh =====
// assertion macros for the pump run and lockout controller
`ifndef PUMP_MOISTURE_RUN_LOCKOUT_CONTROL_ASSERT_SVH
`define PUMP_MOISTURE_RUN_LOCKOUT_CONTROL_ASSERT_SVH

// consequence in the same cycle
`define PMRLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmrlc check failed");

// consequence in the next cycle
`define PMRLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmrlc check failed");

`endif

// ===== src/pmrlc_pkg.sv =====
`default_nettype none

package pmrlc_pkg;

    localparam int CHANNELS_DEF = 4;

    localparam int CH_W    = 2;
    localparam int MOIST_W = 7;
    localparam int SEC_W   = 16;
    localparam int CD_W    = 18;
    localparam int OUT_CD_W = 17;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;

    localparam logic [MOIST_W-1:0] LOW_MOIST_RST  = 7'd60;
    localparam logic [MOIST_W-1:0] HIGH_MOIST_RST = 7'd90;
    localparam logic [SEC_W-1:0]   MAX_RUN_RST    = 16'd300;
    localparam logic [SEC_W-1:0]   LOCKOUT_RST    = 16'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_MOIST  = 2'd0,
        CFG_HIGH_MOIST = 2'd1,
        CFG_MAX_RUN    = 2'd2,
        CFG_LOCKOUT    = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== src/pump_moisture_run_lockout_control.sv =====
`default_nettype none

// Pump run and lockout controller. Each input word is a one-second tick for one
// pump channel and gives exactly one result word for that channel. A tick waits in
// an input register and moves to the result register once the output is free; a new
// tick is taken every cycle while the output does not stall. The channel state is read
// and written back in the single cycle that the tick moves on, so ticks of the same
// channel may follow back to back. Ticks for a channel at or above CHANNELS leave all
// state alone and report zero pump, lockout and countdown fields. Registers should be written
// only while no tick is in flight.

`include "pump_moisture_run_lockout_control_assert.svh"

module pump_moisture_run_lockout_control
    import pmrlc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [SEC_W-1:0]         i_cfg_data,
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    // channel[1:0], moisture[8:2], schedule_hit[9], manual_on[10], zero pad
    input  wire  [IN_TDATA_W-1:0]    s_axis_tdata,
    // auto_mode[0]
    input  wire                      s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // out_channel[1:0], pump_on[2], in_lockout[3], countdown[20:4], zero pad
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic [MOIST_W-1:0] r_low_moist;
    logic [MOIST_W-1:0] r_high_moist;
    logic [SEC_W-1:0]   r_max_run;
    logic [SEC_W-1:0]   r_lockout;

    logic                r_in_vld;
    logic [CH_W-1:0]     r_in_ch;
    logic [MOIST_W-1:0]  r_in_moist;
    logic                r_in_auto;
    logic                r_in_sched;
    logic                r_in_man;

    logic                  r_out_vld;
    logic [CH_W-1:0]       r_out_ch;
    logic                  r_out_pump;
    logic                  r_out_lock;
    logic [OUT_CD_W-1:0]   r_out_cd;

    logic [CHANNELS-1:0]      r_pump;
    logic [CHANNELS-1:0]      r_cyc;
    logic [CHANNELS-1:0]      r_sched;
    logic signed [CD_W-1:0]   r_cd [CHANNELS];

    logic adv;
    logic step;
    logic in_range;

    logic                   cur_pump, cur_cyc, cur_sched;
    logic signed [CD_W-1:0] cur_cd;
    logic                   n_pump, n_cyc, n_sched;
    logic signed [CD_W-1:0] n_cd;
    logic signed [CD_W-1:0] cd_dec;
    logic [CD_W:0]          reload_sum;

    assign o_cfg_ready   = 1'b1;
    assign adv           = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && adv;
    assign s_axis_tready = !r_in_vld || adv;
    assign in_range      = (32'(r_in_ch) < CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_moist  <= LOW_MOIST_RST;
            r_high_moist <= HIGH_MOIST_RST;
            r_max_run    <= MAX_RUN_RST;
            r_lockout    <= LOCKOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_MOIST:  r_low_moist  <= i_cfg_data[MOIST_W-1:0];
                CFG_HIGH_MOIST: r_high_moist <= i_cfg_data[MOIST_W-1:0];
                CFG_MAX_RUN:    r_max_run    <= i_cfg_data;
                CFG_LOCKOUT:    r_lockout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch    <= s_axis_tdata[1:0];
            r_in_moist <= s_axis_tdata[8:2];
            r_in_sched <= s_axis_tdata[9];
            r_in_man   <= s_axis_tdata[10];
            r_in_auto  <= s_axis_tuser;
        end
    end

    // channel state select
    always_comb begin
        cur_pump  = 1'b0;
        cur_cyc   = 1'b0;
        cur_sched = 1'b0;
        cur_cd    = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (32'(r_in_ch) == i) begin
                cur_pump  = r_pump[i];
                cur_cyc   = r_cyc[i];
                cur_sched = r_sched[i];
                cur_cd    = r_cd[i];
            end
        end
    end

    // tick update
    always_comb begin
        n_pump  = cur_pump;
        n_cyc   = cur_cyc;
        n_sched = cur_sched;
        if (r_in_auto) begin
            if (cur_cd < 0) begin
                n_pump = 1'b0;
            end
            if (r_in_moist <= r_low_moist) begin
                if (!cur_cyc) begin
                    n_cyc  = 1'b1;
                    n_pump = 1'b1;
                end
            end else if (r_in_moist >= r_high_moist) begin
                n_pump = 1'b0;
            end else if (cur_sched) begin
                if (!cur_cyc) begin
                    n_cyc  = 1'b1;
                    n_pump = 1'b1;
                end
                n_sched = 1'b0;
            end
        end else begin
            n_pump = r_in_man;
        end
        cd_dec     = n_cyc ? (cur_cd - CD_W'(1)) : cur_cd;
        // countdown plus lockout below zero means past the lockout window
        reload_sum = {cd_dec[CD_W-1], cd_dec} + {{(CD_W+1-SEC_W){1'b0}}, r_lockout};
        n_cd       = cd_dec;
        if (reload_sum[CD_W]) begin
            n_cyc = 1'b0;
            n_cd  = $signed({{(CD_W-SEC_W){1'b0}}, r_max_run});
        end
        if (r_in_sched) begin
            n_sched = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump  <= '0;
            r_cyc   <= '0;
            r_sched <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cd[i] <= $signed({{(CD_W-SEC_W){1'b0}}, MAX_RUN_RST});
            end
        end else if (step && in_range) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (32'(r_in_ch) == i) begin
                    r_pump[i]  <= n_pump;
                    r_cyc[i]   <= n_cyc;
                    r_sched[i] <= n_sched;
                    r_cd[i]    <= n_cd;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
        if (step) begin
            r_out_ch <= r_in_ch;
            if (in_range) begin
                r_out_pump <= n_pump;
                r_out_lock <= n_cyc && n_cd[CD_W-1];
                r_out_cd   <= n_cd[OUT_CD_W-1:0];
            end else begin
                r_out_pump <= 1'b0;
                r_out_lock <= 1'b0;
                r_out_cd   <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_CD_W-CH_W-2){1'b0}},
                            r_out_cd, r_out_lock, r_out_pump, r_out_ch};

    `PMRLC_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_vld && !adv, r_in_vld)
    `PMRLC_ASSERT_NOW(a_lock_neg, i_clk, i_rst_n, r_out_vld && r_out_lock, r_out_cd[OUT_CD_W-1])
    `PMRLC_ASSERT_NOW(a_oor_zero, i_clk, i_rst_n, r_out_vld && (32'(r_out_ch) >= CHANNELS), !r_out_pump && !r_out_lock && (r_out_cd == '0))
    `PMRLC_ASSERT_NOW(a_cd_floor, i_clk, i_rst_n, 1'b1, r_cd[0] >= -65536)

endmodule

`default_nettype wire

// ===== dv/pmrlc_tick_checker.sv =====
`default_nettype none

module pmrlc_tick_checker
    import pmrlc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    input  wire                    i_cfg_ready,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [SEC_W-1:0]        i_cfg_data,
    input  wire                    i_tick_valid,
    input  wire                    i_tick_ready,
    // channel[1:0], moisture[8:2], schedule_hit[9], manual_on[10], zero pad
    input  wire [IN_TDATA_W-1:0]   i_tick_data,
    // auto_mode[0]
    input  wire                    i_tick_auto,
    input  wire                    i_rpt_valid,
    input  wire                    i_rpt_ready,
    // out_channel[1:0], pump_on[2], in_lockout[3], countdown[20:4], zero pad
    input  wire [OUT_TDATA_W-1:0]  i_rpt_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic                pump_on;
        logic                in_lockout;
        logic [OUT_CD_W-1:0] countdown;
    } t_pump_report;

    // shadow of the per-channel controller state
    logic pump_running [CHANNELS_DEF];
    logic cycle_on     [CHANNELS_DEF];
    logic sched_armed  [CHANNELS_DEF];
    int   run_left     [CHANNELS_DEF];

    int dry_level;
    int wet_level;
    int run_ticks;
    int lockout_ticks;
    int mismatches;

    t_pump_report expected_reports[$];

    function automatic t_pump_report irrigate_tick(logic [CH_W-1:0] ch, logic [MOIST_W-1:0] moist,
                                                   logic auto_m, logic sched, logic man);
        t_pump_report r;
        int c;
        int m;
        c = ch;
        m = moist;
        r = '0;
        r.channel = ch;
        if (c >= CHANNELS_DEF) begin
            return r;
        end
        if (auto_m) begin
            if (run_left[c] < 0) begin
                pump_running[c] = 1'b0;
            end
            if (m <= dry_level) begin
                if (!cycle_on[c]) begin
                    cycle_on[c]     = 1'b1;
                    pump_running[c] = 1'b1;
                end
            end else if (m >= wet_level) begin
                pump_running[c] = 1'b0;
            end else if (sched_armed[c]) begin
                if (!cycle_on[c]) begin
                    cycle_on[c]     = 1'b1;
                    pump_running[c] = 1'b1;
                end
                sched_armed[c] = 1'b0;
            end
        end else begin
            pump_running[c] = man;
        end
        if (cycle_on[c]) begin
            run_left[c] = run_left[c] - 1;
        end
        if (run_left[c] < -lockout_ticks) begin
            cycle_on[c] = 1'b0;
            run_left[c] = run_ticks;
        end
        if (sched) begin
            sched_armed[c] = 1'b1;
        end
        r.pump_on    = pump_running[c];
        r.in_lockout = cycle_on[c] && (run_left[c] < 0);
        r.countdown  = OUT_CD_W'(run_left[c]);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pump_report got;
        t_pump_report want;
        if (!i_rst_n) begin
            dry_level     = LOW_MOIST_RST;
            wet_level     = HIGH_MOIST_RST;
            run_ticks     = MAX_RUN_RST;
            lockout_ticks = LOCKOUT_RST;
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                pump_running[c] = 1'b0;
                cycle_on[c]     = 1'b0;
                sched_armed[c]  = 1'b0;
                run_left[c]     = MAX_RUN_RST;
            end
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOW_MOIST:  dry_level     = i_cfg_data[MOIST_W-1:0];
                    CFG_HIGH_MOIST: wet_level     = i_cfg_data[MOIST_W-1:0];
                    CFG_MAX_RUN:    run_ticks     = i_cfg_data;
                    CFG_LOCKOUT:    lockout_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready) begin
                expected_reports.push_back(irrigate_tick(i_tick_data[1:0], i_tick_data[8:2],
                                                         i_tick_auto, i_tick_data[9],
                                                         i_tick_data[10]));
            end
            if (i_rpt_valid && i_rpt_ready) begin
                got.channel    = i_rpt_data[1:0];
                got.pump_on    = i_rpt_data[2];
                got.in_lockout = i_rpt_data[3];
                got.countdown  = i_rpt_data[20:4];
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected report word: ch %0d pump %0b lockout %0b cd %0d",
                                 got.channel, got.pump_on, got.in_lockout,
                                 $signed(got.countdown));
                    end
                end else begin
                    want = expected_reports.pop_front();
                    if (got.channel !== want.channel || got.pump_on !== want.pump_on ||
                        got.in_lockout !== want.in_lockout ||
                        got.countdown !== want.countdown) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("report mismatch: ch exp %0d act %0d, pump exp %0b act %0b",
                                     want.channel, got.channel, want.pump_on, got.pump_on);
                            $display("  lockout exp %0b act %0b, countdown exp %0d act %0d",
                                     want.in_lockout, got.in_lockout,
                                     $signed(want.countdown), $signed(got.countdown));
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_reports.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb_pump_moisture_run_lockout_control.sv =====
`default_nettype none

module tb_pump_moisture_run_lockout_control;
    timeunit 1ns;
    timeprecision 1ps;

    import pmrlc_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 8;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    t_cfg_idx               cfg_index;
    logic [SEC_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int stall_cycles;
    int cur_low;
    int cur_high;
    bit quiet;
    int hold_req;

    pump_moisture_run_lockout_control u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    pmrlc_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_tick_valid (s_tvalid),
        .i_tick_ready (s_tready),
        .i_tick_data  (s_tdata),
        .i_tick_auto  (s_tuser),
        .i_rpt_valid  (m_tvalid),
        .i_rpt_ready  (m_tready),
        .i_rpt_data   (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // report side: random stalls, plus a long hold-off on request
    initial begin
        int n;
        int holds_done;
        holds_done = 0;
        m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                n = HOLD_CYCLES;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 19);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 12);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic send_tick(logic [CH_W-1:0] ch, logic [MOIST_W-1:0] moist, logic auto_m,
                             logic sched, logic man);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, man, sched, moist, ch};
        s_tuser  <= auto_m;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [SEC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic set_config(int lo, int hi, int run, int lock);
        drain();
        put_reg(CFG_LOW_MOIST, SEC_W'(lo));
        put_reg(CFG_HIGH_MOIST, SEC_W'(hi));
        put_reg(CFG_MAX_RUN, SEC_W'(run));
        put_reg(CFG_LOCKOUT, SEC_W'(lock));
        cfg_valid <= 1'b0;
        cur_low  = lo;
        cur_high = hi;
    endtask

    // bias readings toward the dry, middle and wet bands of the current setting
    function automatic logic [MOIST_W-1:0] pick_moisture();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 8) begin
            return MOIST_W'($urandom_range(0, cur_low));
        end else if (sel < 15 && cur_high > cur_low + 1) begin
            return MOIST_W'($urandom_range(cur_low + 1, cur_high - 1));
        end else if (sel < 18) begin
            return MOIST_W'($urandom_range(cur_high, 127));
        end
        return MOIST_W'($urandom_range(0, 127));
    endfunction

    task automatic random_ticks(int n);
        logic [CH_W-1:0] ch;
        logic [MOIST_W-1:0] moist;
        logic auto_m;
        logic sched;
        logic man;
        repeat (n) begin
            ch     = CH_W'($urandom_range(0, 3));
            moist  = pick_moisture();
            auto_m = ($urandom_range(0, 9) < 8);
            sched  = ($urandom_range(0, 3) == 0);
            man    = 1'($urandom_range(0, 1));
            send_tick(ch, moist, auto_m, sched, man);
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LOW_MOIST;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        quiet    = 1'b0;
        hold_req = 0;
        cur_low  = LOW_MOIST_RST;
        cur_high = HIGH_MOIST_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: band edges, readings above one hundred, schedule, manual
        send_tick(2'd0, 7'd0, 1'b1, 1'b0, 1'b0);
        send_tick(2'd1, 7'd127, 1'b1, 1'b0, 1'b0);
        send_tick(2'd2, 7'd100, 1'b1, 1'b1, 1'b0);
        send_tick(2'd2, 7'd75, 1'b1, 1'b0, 1'b0);
        send_tick(2'd3, 7'd60, 1'b1, 1'b0, 1'b0);
        send_tick(2'd3, 7'd90, 1'b1, 1'b0, 1'b0);
        send_tick(2'd1, 7'd61, 1'b1, 1'b0, 1'b0);
        send_tick(2'd1, 7'd89, 1'b1, 1'b1, 1'b0);
        send_tick(2'd1, 7'd89, 1'b0, 1'b0, 1'b1);
        send_tick(2'd1, 7'd64, 1'b0, 1'b0, 1'b0);
        send_tick(2'd1, 7'd70, 1'b1, 1'b0, 1'b0);
        send_tick(2'd0, 7'd0, 1'b0, 1'b1, 1'b1);

        // overlapping thresholds, zero run and lockout
        set_config(100, 0, 0, 0);
        send_tick(2'd0, 7'd50, 1'b1, 1'b0, 1'b0);
        send_tick(2'd0, 7'd127, 1'b1, 1'b0, 1'b0);
        send_tick(2'd1, 7'd101, 1'b1, 1'b1, 1'b0);
        send_tick(2'd1, 7'd101, 1'b1, 1'b0, 1'b0);
        random_ticks(40);

        set_config(0, 100, 65535, 65535);
        send_tick(2'd0, 7'd0, 1'b1, 1'b0, 1'b0);
        send_tick(2'd3, 7'd100, 1'b1, 1'b0, 1'b0);
        random_ticks(40);

        set_config(30, 70, 5, 3);
        hold_req++;
        random_ticks(75);
        hold_req++;
        random_ticks(75);

        set_config(45, 80, 12, 7);
        random_ticks(100);

        set_config(60, 90, 4, 2);
        quiet = 1'b1;
        random_ticks(100);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== pump_moisture_run_lockout_control.f =====
+incdir+src
src/pmrlc_pkg.sv
src/pump_moisture_run_lockout_control.sv
dv/pmrlc_tick_checker.sv
dv/tb_pump_moisture_run_lockout_control.sv
